@@ hdl/prs_pkg.sv @@
// Shared types and constants for the pointer relocation scanner.
package prs_pkg;

  localparam int unsigned DEFAULT_TABLE_DEPTH = 4096;
  localparam int unsigned WORD_W              = 64;
  localparam int unsigned PAIRS_W             = 13;
  localparam int unsigned TOTAL_W             = 32;
  localparam int unsigned CFG_IDX_W           = 3;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_SCAN   = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_UNCHANGED = 3'd0,
    ST_REPLACED  = 3'd1,
    ST_PROTECTED = 3'd2,
    ST_STORED    = 3'd3,
    ST_SKIPPED   = 3'd4,
    ST_FULL      = 3'd5,
    ST_ORDER     = 3'd6,
    ST_CLEARED   = 3'd7
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GA_START = 3'd0,
    REG_GA_END   = 3'd1,
    REG_GB_START = 3'd2,
    REG_GB_END   = 3'd3,
    REG_GC_START = 3'd4,
    REG_GC_END   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [WORD_W-1:0] old_ptr;
    logic [WORD_W-1:0] new_ptr;
  } pair_t;

endpackage

@@ hdl/pointer_relocation_scanner_top.sv @@
// Pointer relocation scanner top level.
//
// Requests enter on start with action, pointer pair and scanned word fields;
// a request is taken when start is high and busy is low. Each request gives
// exactly one result on word_result_o, status_o, replaced_total_o and
// pairs_held_o, marked by done_o for a single cycle. The receiver cannot
// stall; the result must be taken in that cycle.
// Clear, append and the unused action return their result one cycle after
// the request and leave busy low, so a new request may follow right away.
// A scan checks the range first and ends there when the table is empty or
// the word is outside the stored range; otherwise it runs a lower-bound
// search, one table read per step, then a final read of the found entry, all
// through the single read port of the pair memory. Busy is high meanwhile.
// The user writes window registers via cfg_we_i / cfg_idx_i / cfg_wdata_i only
// while the block is idle; the block does not enforce it. Reset empties the
// table, clears the replacement count and all windows but not the pair memory.
module pointer_relocation_scanner_top import prs_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [WORD_W-1:0]    cfg_wdata_i,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           action_i,
  input  logic [WORD_W-1:0]    old_pointer_i,
  input  logic [WORD_W-1:0]    new_pointer_i,
  input  logic [WORD_W-1:0]    word_address_i,
  input  logic [WORD_W-1:0]    word_value_i,
  output logic                 done_o,
  output logic [WORD_W-1:0]    word_result_o,
  output logic [2:0]           status_o,
  output logic [TOTAL_W-1:0]   replaced_total_o,
  output logic [PAIRS_W-1:0]   pairs_held_o
);

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  logic [WORD_W-1:0] scan_addr;
  logic              prot;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr, mem_raddr;
  pair_t             mem_wpair, mem_rpair;

  prs_guard u_guard (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .addr_i      (scan_addr),
    .prot_o      (prot)
  );

  prs_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IDX_W)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wpair_i (mem_wpair),
    .raddr_i (mem_raddr),
    .rpair_o (mem_rpair)
  );

  prs_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .action_i         (action_i),
    .old_pointer_i    (old_pointer_i),
    .new_pointer_i    (new_pointer_i),
    .word_address_i   (word_address_i),
    .word_value_i     (word_value_i),
    .addr_o           (scan_addr),
    .prot_i           (prot),
    .we_o             (mem_we),
    .waddr_o          (mem_waddr),
    .wpair_o          (mem_wpair),
    .raddr_o          (mem_raddr),
    .rpair_i          (mem_rpair),
    .done_o           (done_o),
    .word_result_o    (word_result_o),
    .status_o         (status_o),
    .replaced_total_o (replaced_total_o),
    .pairs_held_o     (pairs_held_o)
  );

endmodule

@@ hdl/prs_table.sv @@
// Pair table memory: one write port, one registered read port.
module prs_table import prs_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
  parameter int unsigned IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  pair_t            wpair_i,
  input  logic [IDX_W-1:0] raddr_i,
  output pair_t            rpair_o
);

  pair_t mem_q [TABLE_DEPTH];
  pair_t rpair_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wpair_i;
    end
    rpair_q <= mem_q[raddr_i];
  end

  assign rpair_o = rpair_q;

endmodule

@@ hdl/prs_guard.sv @@
// Protected window registers and registered address-in-window check.
module prs_guard import prs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [WORD_W-1:0]    cfg_wdata_i,
  input  logic [WORD_W-1:0]    addr_i,
  output logic                 prot_o
);

  logic [WORD_W-1:0] ga_start_q, ga_end_q;
  logic [WORD_W-1:0] gb_start_q, gb_end_q;
  logic [WORD_W-1:0] gc_start_q, gc_end_q;
  logic              prot_d, prot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ga_start_q <= '0;
      ga_end_q   <= '0;
      gb_start_q <= '0;
      gb_end_q   <= '0;
      gc_start_q <= '0;
      gc_end_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GA_START: ga_start_q <= cfg_wdata_i;
        REG_GA_END:   ga_end_q   <= cfg_wdata_i;
        REG_GB_START: gb_start_q <= cfg_wdata_i;
        REG_GB_END:   gb_end_q   <= cfg_wdata_i;
        REG_GC_START: gc_start_q <= cfg_wdata_i;
        REG_GC_END:   gc_end_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign prot_d = (addr_i >= ga_start_q && addr_i < ga_end_q) ||
                  (addr_i >= gb_start_q && addr_i < gb_end_q) ||
                  (addr_i >= gc_start_q && addr_i < gc_end_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prot_q <= 1'b0;
    end else begin
      prot_q <= prot_d;
    end
  end

  assign prot_o = prot_q;

endmodule

@@ hdl/prs_ctrl.sv @@
// Request sequencer: table load, range check and lower-bound search.
module prs_ctrl import prs_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
  parameter int unsigned IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  parameter int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action_i,
  input  logic [WORD_W-1:0]  old_pointer_i,
  input  logic [WORD_W-1:0]  new_pointer_i,
  input  logic [WORD_W-1:0]  word_address_i,
  input  logic [WORD_W-1:0]  word_value_i,
  output logic [WORD_W-1:0]  addr_o,
  input  logic               prot_i,
  output logic               we_o,
  output logic [IDX_W-1:0]   waddr_o,
  output pair_t              wpair_o,
  output logic [IDX_W-1:0]   raddr_o,
  input  pair_t              rpair_i,
  output logic               done_o,
  output logic [WORD_W-1:0]  word_result_o,
  output logic [2:0]         status_o,
  output logic [TOTAL_W-1:0] replaced_total_o,
  output logic [PAIRS_W-1:0] pairs_held_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RANGE = 4'b0010,
    S_STEP  = 4'b0100,
    S_CHECK = 4'b1000
  } state_e;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  state_e              state_d, state_q;
  logic [WORD_W-1:0]   key_d, key_q;
  logic [WORD_W-1:0]   addr_d, addr_q;
  logic [CNT_W-1:0]    lo_d, lo_q, hi_d, hi_q, mid_d, mid_q;
  logic [CNT_W-1:0]    count_d, count_q;
  logic [WORD_W-1:0]   lowest_d, lowest_q, highest_d, highest_q;
  logic [TOTAL_W-1:0]  rc_d, rc_q;
  logic                done_d, done_q;
  logic [WORD_W-1:0]   result_d, result_q;
  status_e             status_d, status_q;
  logic                accept;
  logic [CNT_W-1:0]    rd_idx, nlo, nhi;
  logic [CNT_W:0]      sum;
  logic [CNT_W+PAIRS_W-1:0] count_ext;

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q != S_IDLE);

  always_comb begin
    state_d   = state_q;
    key_d     = key_q;
    addr_d    = addr_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    count_d   = count_q;
    lowest_d  = lowest_q;
    highest_d = highest_q;
    rc_d      = rc_q;
    done_d    = 1'b0;
    result_d  = result_q;
    status_d  = status_q;
    we_o      = 1'b0;
    rd_idx    = mid_q;
    nlo       = lo_q;
    nhi       = hi_q;
    sum       = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (action_e'(action_i))
            ACT_CLEAR: begin
              count_d   = '0;
              lowest_d  = '1;
              highest_d = '0;
              rc_d      = '0;
              done_d    = 1'b1;
              result_d  = '0;
              status_d  = ST_CLEARED;
            end
            ACT_APPEND: begin
              done_d   = 1'b1;
              result_d = '0;
              if (old_pointer_i == '0 || old_pointer_i == new_pointer_i) begin
                status_d = ST_SKIPPED;
              end else if (count_q == DEPTH_CNT) begin
                status_d = ST_FULL;
              end else if (count_q != '0 && old_pointer_i < highest_q) begin
                // highest old value is the last one stored, as loads are ordered
                status_d = ST_ORDER;
              end else begin
                status_d = ST_STORED;
                we_o     = 1'b1;
                count_d  = count_q + CNT_W'(1);
                if (old_pointer_i < lowest_q) begin
                  lowest_d = old_pointer_i;
                end
                if (old_pointer_i > highest_q) begin
                  highest_d = old_pointer_i;
                end
              end
            end
            ACT_SCAN: begin
              key_d   = word_value_i;
              addr_d  = word_address_i;
              state_d = S_RANGE;
            end
            default: begin
              done_d   = 1'b1;
              result_d = word_value_i;
              status_d = ST_UNCHANGED;
            end
          endcase
        end
      end
      S_RANGE: begin
        if (count_q == '0 || key_q < lowest_q || key_q > highest_q) begin
          done_d   = 1'b1;
          result_d = key_q;
          status_d = ST_UNCHANGED;
          state_d  = S_IDLE;
        end else begin
          lo_d    = '0;
          hi_d    = count_q;
          rd_idx  = count_q >> 1;
          mid_d   = rd_idx;
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        if (rpair_i.old_ptr < key_q) begin
          nlo = mid_q + CNT_W'(1);
        end else begin
          nhi = mid_q;
        end
        lo_d = nlo;
        hi_d = nhi;
        sum  = {1'b0, nlo} + {1'b0, nhi};
        if (nlo < nhi) begin
          rd_idx = sum[CNT_W:1];
          mid_d  = rd_idx;
        end else begin
          rd_idx  = nlo;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        if (lo_q < count_q && rpair_i.old_ptr == key_q) begin
          if (prot_i) begin
            result_d = key_q;
            status_d = ST_PROTECTED;
          end else begin
            result_d = rpair_i.new_ptr;
            status_d = ST_REPLACED;
            if (rc_q != '1) begin
              rc_d = rc_q + TOTAL_W'(1);
            end
          end
        end else begin
          result_d = key_q;
          status_d = ST_UNCHANGED;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      lowest_q  <= '1;
      highest_q <= '0;
      rc_q      <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      lowest_q  <= lowest_d;
      highest_q <= highest_d;
      rc_q      <= rc_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    addr_q   <= addr_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    result_q <= result_d;
    status_q <= status_d;
  end

  assign waddr_o         = count_q[IDX_W-1:0];
  assign wpair_o.old_ptr = old_pointer_i;
  assign wpair_o.new_ptr = new_pointer_i;
  assign raddr_o         = rd_idx[IDX_W-1:0];
  assign addr_o          = addr_q;

  assign count_ext        = {{PAIRS_W{1'b0}}, count_q};
  assign done_o           = done_q;
  assign word_result_o    = result_q;
  assign status_o         = status_q;
  assign replaced_total_o = rc_q;
  assign pairs_held_o     = count_ext[PAIRS_W-1:0];

endmodule
